// ===== rtl/ovn_pkg.sv =====
// Package: shared types, constants and the blend function of the 3D value noise block.
package ovn_pkg;

	localparam int MAX_OCTAVES_DEF     = 8;
	localparam int COORD_FRAC_BITS_DEF = 8;

	// octave counter width, sized for the largest octave count supported
	localparam int OCT_W = 5;
	localparam int DVS_W = 40;
	localparam int REM_W = DVS_W + 1;
	localparam int NB_W  = 7;

	// quotient bits per divide kind
	localparam logic [NB_W-1:0] NB_RES = 7'd24;
	localparam logic [NB_W-1:0] NB_IDX = 7'd50;
	localparam logic [NB_W-1:0] NB_FRC = 7'd17;
	localparam logic [NB_W-1:0] NB_FIN = 7'd40;

	localparam logic [7:0] CFG_OCTAVES = 8'd0;
	localparam logic [7:0] CFG_PERSIST = 8'd1;
	localparam logic [7:0] CFG_LACUN   = 8'd2;
	localparam logic [7:0] CFG_BASERES = 8'd3;
	localparam logic [7:0] CFG_SEED    = 8'd4;

	localparam logic [31:0] HASH_K_LO = 32'h7f4a7c15;
	localparam logic [31:0] HASH_K_HI = 32'h9e3779b9;
	localparam logic [31:0] HASH_M2   = 32'h27d4eb2d;
	localparam logic signed [27:0] PRIME_X = 28'sd73856093;
	localparam logic signed [27:0] PRIME_Y = 28'sd19349663;
	localparam logic signed [27:0] PRIME_Z = 28'sd83492791;
	localparam logic [63:0] OFFS_X = 64'd54209;
	localparam logic [63:0] OFFS_Y = 64'd129871;
	localparam logic [63:0] OFFS_Z = 64'd82731;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SEED_MUL, ST_SEED_ADD, ST_OCT_SCALE, ST_DIV_GO, ST_DIV_WAIT,
		ST_HASH, ST_HASH_WAIT, ST_ACCUM, ST_FIN_GO, ST_FIN_WAIT, ST_OUT_WAIT
	} state_t;

	typedef enum logic [2:0] {
		DS_RES, DS_IX, DS_IY, DS_IZ, DS_FX, DS_FY, DS_FZ, DS_FIN
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     seed_mul;
		logic     seed_add;
		logic     scale;
		logic     div_start;
		div_sel_t div_sel;
		logic     hash_issue;
		logic [2:0] corner;
		logic     accum;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic lat_done;
		logic out_busy;
		logic [OCT_W-1:0] oct_n;
	} status_t;

	// floor((a*(65536-t) + b*t) / 65536)
	function automatic logic [15:0] blend16(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] t);
		logic [32:0] pa;
		logic [32:0] pb;
		logic [32:0] s;
		pa = 33'(a) * 33'(17'h10000 - {1'b0, t});
		pb = 33'(b) * 33'(t);
		s  = pa + pb;
		return s[31:16];
	endfunction

endpackage

// ===== rtl/ovn_div.sv =====
// Iterative signed-by-unsigned floor divider, one quotient bit per cycle.
module ovn_div
	import ovn_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [63:0]      dividend,
	input  logic [DVS_W-1:0]        divisor,
	input  logic [NB_W-1:0]         nbits,
	output logic                    done,
	output logic [63:0]             quot,
	output logic [DVS_W-1:0]        rem
);

	logic              busy_q, fix_q, done_q, neg_q;
	logic [NB_W-1:0]   cnt_q;
	logic [63:0]       mag_q, q_q, quot_q;
	logic [REM_W-1:0]  r_q;
	logic [DVS_W-1:0]  d_q, rem_q;
	logic [63:0]       mag_in, shr;
	logic              nbit;
	logic [REM_W:0]    trial;

	assign mag_in = dividend[63] ? 64'(-dividend) : 64'(dividend);
	assign shr    = mag_in >> nbits;
	assign nbit   = mag_q[6'(cnt_q - 7'd1)];
	assign trial  = {1'b0, r_q[REM_W-2:0], nbit} - {2'b00, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					fix_q  <= 1'b1;
				end
			end else if (fix_q) begin
				fix_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag_in;
			neg_q <= dividend[63];
			d_q   <= divisor;
			r_q   <= shr[REM_W-1:0];
			q_q   <= '0;
		end else if (busy_q) begin
			if (!trial[REM_W]) begin
				r_q <= trial[REM_W-1:0];
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				r_q <= {r_q[REM_W-2:0], nbit};
				q_q <= {q_q[62:0], 1'b0};
			end
		end else if (fix_q) begin
			// negative dividend: floor quotient, remainder folded into [0, d)
			if (neg_q && (r_q != '0)) begin
				quot_q <= ~q_q;
				rem_q  <= d_q - r_q[DVS_W-1:0];
			end else if (neg_q) begin
				quot_q <= 64'(-q_q);
				rem_q  <= '0;
			end else begin
				quot_q <= q_q;
				rem_q  <= r_q[DVS_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/ovn_dp.sv =====
// Datapath: config registers, octave state, divider, corner hash pipeline, blend tree.
module ovn_dp
	import ovn_pkg::*;
#(
	parameter int MAX_OCTAVES     = MAX_OCTAVES_DEF,
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [95:0] s_tdata,
	input  logic        m_tready,
	output logic        m_tvalid,
	output logic [15:0] m_tdata,
	input  cmd_t        cmd,
	output status_t     st
);

	localparam logic [63:0] STEP_X = OFFS_X << COORD_FRAC_BITS;
	localparam logic [63:0] STEP_Y = OFFS_Y << COORD_FRAC_BITS;
	localparam logic [63:0] STEP_Z = OFFS_Z << COORD_FRAC_BITS;

	logic [3:0]  oct_cfg_q;
	logic [15:0] pers_q;
	logic [11:0] lac_q;
	logic [12:0] base_q;
	logic [31:0] seed_q;

	logic signed [31:0] x_q, y_q, z_q;
	logic [63:0] sp_lo_q, sm2_q, seedk_q;
	logic [31:0] sp_hi_q;
	logic [24:0] freq_q;
	logic [16:0] amp_q;
	logic signed [39:0] total_q;
	logic [20:0] norm_q;
	logic signed [63:0] offx_q, offy_q, offz_q;
	logic signed [57:0] px_q, py_q, pz_q;
	logic [21:0] res_q;
	logic [31:0] ix_q, iy_q, iz_q;
	logic [DVS_W-1:0] rx_q, ry_q, rz_q;
	logic [15:0] fx_q, fy_q, fz_q;
	logic [15:0] fin_q;
	logic        mv_q;
	logic [15:0] md_q;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oct_cfg_q <= 4'd4;
			pers_q    <= 16'd32768;
			lac_q     <= 12'd512;
			base_q    <= 13'd64;
			seed_q    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_OCTAVES: oct_cfg_q <= cfg_data[3:0];
				CFG_PERSIST: pers_q    <= cfg_data[15:0];
				CFG_LACUN:   lac_q     <= cfg_data[11:0];
				CFG_BASERES: base_q    <= cfg_data[12:0];
				CFG_SEED:    seed_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (oct_cfg_q == 4'd0)
			st.oct_n = OCT_W'(1);
		else if ({1'b0, oct_cfg_q} > OCT_W'(MAX_OCTAVES))
			st.oct_n = OCT_W'(MAX_OCTAVES);
		else
			st.oct_n = OCT_W'(oct_cfg_q);
	end

	// divider operand selection
	logic signed [63:0] dv_a;
	logic [DVS_W-1:0]   dv_d, cell_len;
	logic [NB_W-1:0]    dv_n;
	logic               dv_done;
	logic [63:0]        dv_q;
	logic [DVS_W-1:0]   dv_r;

	assign cell_len = DVS_W'(res_q) << COORD_FRAC_BITS;

	always_comb begin
		dv_a = '0;
		dv_d = cell_len;
		dv_n = NB_IDX;
		case (cmd.div_sel)
			DS_RES: begin
				dv_a = 64'({base_q, 8'b0});
				dv_d = DVS_W'(freq_q);
				dv_n = NB_RES;
			end
			DS_IX: dv_a = (64'(px_q) >>> 8) + offx_q;
			DS_IY: dv_a = (64'(py_q) >>> 8) + offy_q;
			DS_IZ: dv_a = (64'(pz_q) >>> 8) + offz_q;
			DS_FX: begin
				dv_a = 64'({rx_q, 16'b0});
				dv_n = NB_FRC;
			end
			DS_FY: begin
				dv_a = 64'({ry_q, 16'b0});
				dv_n = NB_FRC;
			end
			DS_FZ: begin
				dv_a = 64'({rz_q, 16'b0});
				dv_n = NB_FRC;
			end
			DS_FIN: begin
				dv_a = 64'(total_q);
				dv_d = DVS_W'({norm_q, 1'b0});
				dv_n = NB_FIN;
			end
			default: ;
		endcase
	end

	ovn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dv_a),
		.divisor  (dv_d),
		.nbits    (dv_n),
		.done     (dv_done),
		.quot     (dv_q),
		.rem      (dv_r)
	);

	assign st.div_done = dv_done;

	// octave and item state
	logic [36:0] fprod;
	logic [28:0] fnext;
	logic [32:0] aprod;
	logic signed [17:0] lat_term;
	logic signed [35:0] tprod;
	logic [15:0] lat_q;
	logic signed [63:0] qs;

	assign fprod    = 37'(freq_q) * 37'(lac_q);
	assign fnext    = fprod[36:8];
	assign aprod    = 33'(amp_q) * 33'(pers_q);
	assign lat_term = $signed({1'b0, lat_q, 1'b0}) - 18'sd65536;
	assign tprod    = lat_term * $signed({1'b0, amp_q});
	assign qs       = $signed(dv_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= s_tdata[31:0];
			y_q     <= s_tdata[63:32];
			z_q     <= s_tdata[95:64];
			freq_q  <= 25'd256;
			amp_q   <= 17'h10000;
			total_q <= '0;
			norm_q  <= '0;
			offx_q  <= '0;
			offy_q  <= '0;
			offz_q  <= '0;
		end
		if (cmd.seed_mul) begin
			sp_lo_q <= seed_q * HASH_K_LO;
			sp_hi_q <= 32'(seed_q * HASH_K_HI);
			sm2_q   <= seed_q * HASH_M2;
		end
		if (cmd.seed_add)
			seedk_q <= sp_lo_q + {sp_hi_q, 32'b0};
		if (cmd.scale) begin
			px_q <= x_q * $signed({1'b0, freq_q});
			py_q <= y_q * $signed({1'b0, freq_q});
			pz_q <= z_q * $signed({1'b0, freq_q});
		end
		if (dv_done) begin
			case (cmd.div_sel)
				DS_RES: res_q <= (dv_q == '0) ? 22'd1 : dv_q[21:0];
				DS_IX: begin
					ix_q <= dv_q[31:0];
					rx_q <= dv_r;
				end
				DS_IY: begin
					iy_q <= dv_q[31:0];
					ry_q <= dv_r;
				end
				DS_IZ: begin
					iz_q <= dv_q[31:0];
					rz_q <= dv_r;
				end
				DS_FX: fx_q <= dv_q[15:0];
				DS_FY: fy_q <= dv_q[15:0];
				DS_FZ: fz_q <= dv_q[15:0];
				DS_FIN: begin
					if (qs > 64'sd32767)
						fin_q <= 16'h7fff;
					else if (qs < -64'sd32768)
						fin_q <= 16'h8000;
					else
						fin_q <= dv_q[15:0];
				end
				default: ;
			endcase
		end
		if (cmd.accum) begin
			total_q <= total_q + 40'(tprod);
			norm_q  <= norm_q + 21'(amp_q);
			amp_q   <= aprod[32:16];
			if (fnext == '0)
				freq_q <= 25'd1;
			else if (fnext > 29'h1000000)
				freq_q <= 25'h1000000;
			else
				freq_q <= fnext[24:0];
			offx_q <= offx_q + STEP_X;
			offy_q <= offy_q + STEP_Y;
			offz_q <= offz_q + STEP_Z;
		end
	end

	// corner hash pipeline
	logic [31:0] cx, cy, cz;
	logic signed [59:0] mx, my, mz;
	logic [63:0] n_s1, k_s2, k_s3, k_s4, k2, k4, k6, k7;
	logic [15:0] v_s5;
	logic hv_s1, hv_s2, hv_s3, hv_s4, hv_s5;

	assign cx = cmd.corner[0] ? ix_q + 32'd1 : ix_q;
	assign cy = cmd.corner[1] ? iy_q + 32'd1 : iy_q;
	assign cz = cmd.corner[2] ? iz_q + 32'd1 : iz_q;
	assign mx = $signed(cx) * PRIME_X;
	assign my = $signed(cy) * PRIME_Y;
	assign mz = $signed(cz) * PRIME_Z;
	assign k2 = ~k_s2 + (k_s2 << 18);
	assign k4 = (k_s3 << 4) + (k_s3 << 2) + k_s3;
	assign k6 = k_s4 + (k_s4 << 6);
	assign k7 = k6 ^ (k6 >> 22) ^ sm2_q;

	always_ff @(posedge clk) begin
		n_s1 <= 64'(mx) ^ 64'(my) ^ 64'(mz);
		k_s2 <= n_s1 + seedk_q;
		k_s3 <= k2 ^ (k2 >> 31);
		k_s4 <= k4 ^ (k4 >> 11);
		v_s5 <= k7[30:15];
	end

	// blend tree: each level pairs consecutive items in arrival order
	logic p0_q, p1_q, p2_q, v1_q, v2_q, lv_q;
	logic [15:0] h0_q, h1_q, h2_q, d1_q, d2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_s1 <= 1'b0;
			hv_s2 <= 1'b0;
			hv_s3 <= 1'b0;
			hv_s4 <= 1'b0;
			hv_s5 <= 1'b0;
			p0_q  <= 1'b0;
			p1_q  <= 1'b0;
			p2_q  <= 1'b0;
			v1_q  <= 1'b0;
			v2_q  <= 1'b0;
			lv_q  <= 1'b0;
		end else begin
			hv_s1 <= cmd.hash_issue;
			hv_s2 <= hv_s1;
			hv_s3 <= hv_s2;
			hv_s4 <= hv_s3;
			hv_s5 <= hv_s4;
			v1_q  <= hv_s5 && p0_q;
			v2_q  <= v1_q && p1_q;
			lv_q  <= v2_q && p2_q;
			if (hv_s5)
				p0_q <= !p0_q;
			if (v1_q)
				p1_q <= !p1_q;
			if (v2_q)
				p2_q <= !p2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (hv_s5 && !p0_q)
			h0_q <= v_s5;
		if (hv_s5 && p0_q)
			d1_q <= blend16(h0_q, v_s5, fx_q);
		if (v1_q && !p1_q)
			h1_q <= d1_q;
		if (v1_q && p1_q)
			d2_q <= blend16(h1_q, d1_q, fy_q);
		if (v2_q && !p2_q)
			h2_q <= d2_q;
		if (v2_q && p2_q)
			lat_q <= blend16(h2_q, d2_q, fz_q);
	end

	assign st.lat_done = lv_q;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mv_q <= 1'b0;
		else if (cmd.out_load)
			mv_q <= 1'b1;
		else if (m_tready)
			mv_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load)
			md_q <= fin_q;
	end

	assign st.out_busy = mv_q;
	assign m_tvalid    = mv_q;
	assign m_tdata     = md_q;

endmodule

// ===== rtl/ovn_ctrl.sv =====
// Controller: sequences seed setup, octaves, divides, corner hashing and the final divide.
module ovn_ctrl
	import ovn_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  status_t st,
	output cmd_t    cmd
);

	state_t          state_q, state_d;
	div_sel_t        sel_q;
	logic [2:0]      corner_q;
	logic [OCT_W-1:0] oct_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (s_tvalid) state_d = ST_SEED_MUL;
			ST_SEED_MUL:  state_d = ST_SEED_ADD;
			ST_SEED_ADD:  state_d = ST_OCT_SCALE;
			ST_OCT_SCALE: state_d = ST_DIV_GO;
			ST_DIV_GO:    state_d = ST_DIV_WAIT;
			ST_DIV_WAIT:  if (st.div_done) state_d = (sel_q == DS_FZ) ? ST_HASH : ST_DIV_GO;
			ST_HASH:      if (corner_q == 3'd7) state_d = ST_HASH_WAIT;
			ST_HASH_WAIT: if (st.lat_done) state_d = ST_ACCUM;
			ST_ACCUM:     state_d = (oct_q + OCT_W'(1) == st.oct_n) ? ST_FIN_GO : ST_OCT_SCALE;
			ST_FIN_GO:    state_d = ST_FIN_WAIT;
			ST_FIN_WAIT:  if (st.div_done) state_d = ST_OUT_WAIT;
			ST_OUT_WAIT:  if (!st.out_busy) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			sel_q    <= DS_RES;
			corner_q <= '0;
			oct_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OCT_SCALE)
				sel_q <= DS_RES;
			else if (state_q == ST_DIV_WAIT && st.div_done && sel_q != DS_FZ)
				sel_q <= div_sel_t'(sel_q + 3'd1);
			if (state_q == ST_HASH)
				corner_q <= corner_q + 3'd1;
			if (state_q == ST_IDLE)
				oct_q <= '0;
			else if (state_q == ST_ACCUM)
				oct_q <= oct_q + OCT_W'(1);
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.div_sel = sel_q;
		cmd.corner  = corner_q;
		case (state_q)
			ST_IDLE:      cmd.load = s_tvalid;
			ST_SEED_MUL:  cmd.seed_mul = 1'b1;
			ST_SEED_ADD:  cmd.seed_add = 1'b1;
			ST_OCT_SCALE: cmd.scale = 1'b1;
			ST_DIV_GO:    cmd.div_start = 1'b1;
			ST_HASH:      cmd.hash_issue = 1'b1;
			ST_ACCUM:     cmd.accum = 1'b1;
			ST_FIN_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DS_FIN;
			end
			ST_FIN_WAIT:  cmd.div_sel = DS_FIN;
			ST_OUT_WAIT:  cmd.out_load = !st.out_busy;
			default: ;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);

endmodule

// ===== rtl/octave_value_noise_3d.sv =====
// Top level of the layered 3D value noise block.
// One point is taken at a time; its result goes to an output register, so the next point is
// accepted while that result waits. Per octave the item takes one 24-bit divide for the cell size,
// three 50-bit floor divides for the cell indices and three 17-bit divides for the fractions
// on one shared bit-serial divider, then eight corner hashes issued back to back into a
// five-stage hash pipe and a three-level blend tree; the final 40-bit divide by twice the
// summed amplitudes closes the item. A result still waiting in the output register holds the
// next item in its last step.
module octave_value_noise_3d
	import ovn_pkg::*;
#(
	parameter int MAX_OCTAVES     = MAX_OCTAVES_DEF,
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // x_coord[31:0], y_coord[63:32], z_coord[95:64]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // noise_value[15:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cmd_t    cmd;
	status_t st;

	assign cfg_ready = 1'b1;

	ovn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	ovn_dp #(
		.MAX_OCTAVES     (MAX_OCTAVES),
		.COORD_FRAC_BITS (COORD_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.st        (st)
	);

endmodule

// ===== rtl/ovn_checker.sv =====
// Port checker for the layered 3D value noise block, bound to the top level.
module ovn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item accepted while busy");

	// no result right after accepting an item
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared without computation");

	// the block becomes ready again only as it hands off a result
	a_ready_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_tready) |-> $rose(m_tvalid))
		else $error("ready returned without a result");

endmodule

bind octave_value_noise_3d ovn_checker u_chk (.*);

// ===== dv/tb.sv =====
// Testbench for octave_value_noise_3d: random points checked against a fixed-point noise predictor.
`timescale 1ns / 1ps

module tb;
	import ovn_pkg::*;

	localparam logic [7:0] CFG_BAD_INDEX = 8'd7;

	typedef struct packed {
		logic [31:0] z;
		logic [31:0] y;
		logic [31:0] x;
	} point_t;

	typedef struct {
		logic [3:0]  octaves;
		logic [15:0] persist;
		logic [11:0] lacun;
		logic [12:0] res_base;
		logic [31:0] seed;
	} noise_cfg_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;   // x_coord[31:0], y_coord[63:32], z_coord[95:64]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // noise_value[15:0]
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [31:0] cfg_data;

	noise_cfg_t  shadow;
	point_t      pending_points[$];
	logic [15:0] expected_noise[$];
	int          mismatches;
	bit          point_taken;
	int          burst_left;
	int          gap_left;
	int          stall_mode;
	int          mode_left;

	octave_value_noise_3d DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic longint floor_quot(input longint a, input longint d);
		longint q;
		q = a / d;
		if ((a % d) != 0 && a < 0)
			q--;
		return q;
	endfunction

	function automatic logic [15:0] corner_value(input logic [31:0] cx, input logic [31:0] cy,
			input logic [31:0] cz, input logic [31:0] seed);
		logic [63:0] k;
		logic [63:0] s64;
		s64 = {32'b0, seed};
		k = ({{32{cx[31]}}, cx} * 64'd73856093) ^ ({{32{cy[31]}}, cy} * 64'd19349663)
			^ ({{32{cz[31]}}, cz} * 64'd83492791);
		k = k + s64 * 64'h9e3779b97f4a7c15;
		k = (~k) + (k << 18);
		k = k ^ (k >> 31);
		k = k * 64'd21;
		k = k ^ (k >> 11);
		k = k + (k << 6);
		k = k ^ (k >> 22);
		k = k ^ (s64 * 64'h27d4eb2d);
		return k[30:15];
	endfunction

	function automatic logic [15:0] lerp16(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] t);
		logic [63:0] s;
		s = 64'(a) * (64'd65536 - 64'(t)) + 64'(b) * 64'(t);
		return s[31:16];
	endfunction

	function automatic logic [15:0] predict_noise(input point_t p, input noise_cfg_t c);
		longint coord[3];
		longint offs[3];
		longint scaled, q, r, cell_len, res, v;
		longint freq, amp, total, norm, result;
		logic [31:0] lo[3];
		logic [31:0] hi[3];
		logic [15:0] frac[3];
		logic [15:0] cv[8];
		logic [15:0] x00, x10, x01, x11, y0, y1;
		int n;
		coord[0] = longint'($signed(p.x));
		coord[1] = longint'($signed(p.y));
		coord[2] = longint'($signed(p.z));
		offs[0] = 54209;
		offs[1] = 129871;
		offs[2] = 82731;
		freq = 256;
		amp = 65536;
		total = 0;
		norm = 0;
		n = c.octaves;
		if (n < 1)
			n = 1;
		if (n > 8)
			n = 8;
		for (int i = 0; i < n; i++) begin
			res = (longint'(c.res_base) * 256) / freq;
			if (res < 1)
				res = 1;
			cell_len = res * 256;
			for (int a = 0; a < 3; a++) begin
				scaled = floor_quot(coord[a] * freq, 256) + longint'(i) * offs[a] * 256;
				q = floor_quot(scaled, cell_len);
				r = scaled - q * cell_len;
				lo[a] = q[31:0];
				hi[a] = lo[a] + 32'd1;
				frac[a] = 16'((r * 65536) / cell_len);
			end
			for (int k = 0; k < 8; k++)
				cv[k] = corner_value(k[0] ? hi[0] : lo[0], k[1] ? hi[1] : lo[1],
					k[2] ? hi[2] : lo[2], c.seed);
			x00 = lerp16(cv[0], cv[1], frac[0]);
			x10 = lerp16(cv[2], cv[3], frac[0]);
			x01 = lerp16(cv[4], cv[5], frac[0]);
			x11 = lerp16(cv[6], cv[7], frac[0]);
			y0 = lerp16(x00, x10, frac[1]);
			y1 = lerp16(x01, x11, frac[1]);
			v = longint'(lerp16(y0, y1, frac[2])) * 2 - 65536;
			total += v * amp;
			norm += amp;
			amp = (amp * longint'(c.persist)) >>> 16;
			freq = (freq * longint'(c.lacun)) >>> 8;
			if (freq < 1)
				freq = 1;
			if (freq > (longint'(1) << 24))
				freq = longint'(1) << 24;
		end
		result = floor_quot(total, norm * 2);
		if (result > 32767)
			result = 32767;
		if (result < -32768)
			result = -32768;
		return result[15:0];
	endfunction

	// register mirror follows accepted writes
	always @(posedge clk) begin
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_OCTAVES: shadow.octaves = cfg_data[3:0];
				CFG_PERSIST: shadow.persist = cfg_data[15:0];
				CFG_LACUN: shadow.lacun = cfg_data[11:0];
				CFG_BASERES: shadow.res_base = cfg_data[12:0];
				CFG_SEED: shadow.seed = cfg_data;
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			expected_noise.push_back(predict_noise(point_t'(s_tdata), shadow));
			point_taken = 1'b1;
		end
	end

	always @(posedge clk) begin
		logic [15:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_noise.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", m_tdata));
			end else begin
				want = expected_noise.pop_front();
				if (m_tdata !== want)
					report_mismatch($sformatf("noise_value got %h want %h", m_tdata, want));
			end
		end
	end

	// sender: bursts with gaps
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !point_taken)) begin
			point_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_points.size() > 0) begin
				s_tdata <= pending_points.pop_front();
				s_tvalid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern switches between none, light and heavy
	always @(negedge clk) begin
		if (mode_left <= 0) begin
			stall_mode = $urandom_range(0, 2);
			mode_left = $urandom_range(20, 3000);
		end
		mode_left--;
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			default: m_tready <= ($urandom_range(0, 9) == 0);
		endcase
	end

	task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// the last point must have left the driver before the queues count as empty
	task automatic wait_drained();
		wait (pending_points.size() == 0 && !s_tvalid && expected_noise.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6: return 32'($signed($urandom_range(0, 131071)) - 65536);
			default: return 32'($signed($urandom_range(0, 1023)) - 512);
		endcase
	endfunction

	task automatic add_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		point_t p;
		p.x = x;
		p.y = y;
		p.z = z;
		pending_points.push_back(p);
	endtask

	task automatic add_edge_points();
		add_point(32'h0, 32'h0, 32'h0);
		add_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		add_point(32'h80000000, 32'h80000000, 32'h80000000);
		add_point(32'hffffffff, 32'hffffffff, 32'hffffffff);
		add_point(32'h7fffffff, 32'h80000000, 32'h0);
		add_point(32'h1, 32'hff, 32'h100);
		add_point(32'hffffff00, 32'h3fff, 32'hffffc001);
	endtask

	task automatic add_random_points(input int count);
		for (int i = 0; i < count; i++)
			add_point(rand_coord(), rand_coord(), rand_coord());
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_OCTAVES;
		cfg_data = '0;
		shadow = '{octaves: 4'd4, persist: 16'd32768, lacun: 12'd512, res_base: 13'd64,
			seed: 32'd0};
		mismatches = 0;
		point_taken = 1'b0;
		burst_left = 0;
		gap_left = 0;
		mode_left = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings
		add_edge_points();
		add_random_points(130);
		wait_drained();

		// zero octaves, zero persistence, zero lacunarity, zero base resolution
		write_reg(CFG_OCTAVES, 32'd0);
		write_reg(CFG_PERSIST, 32'd0);
		write_reg(CFG_LACUN, 32'd0);
		write_reg(CFG_BASERES, 32'd0);
		write_reg(CFG_SEED, 32'hffffffff);
		add_edge_points();
		add_random_points(40);
		wait_drained();
		write_reg(CFG_OCTAVES, 32'd3);
		add_point(32'h12345, 32'hfff01234, 32'h0);
		add_random_points(60);
		wait_drained();

		// too many octaves, frequency overflow, widest cells; bad index ignored
		write_reg(CFG_OCTAVES, 32'hffffffff);
		write_reg(CFG_PERSIST, 32'd65535);
		write_reg(CFG_LACUN, 32'd4095);
		write_reg(CFG_BASERES, 32'd8191);
		write_reg(CFG_BAD_INDEX, 32'h1);
		add_edge_points();
		add_random_points(100);
		wait_drained();

		// legal extremes
		write_reg(CFG_OCTAVES, 32'd8);
		write_reg(CFG_LACUN, 32'd256);
		write_reg(CFG_BASERES, 32'd1);
		write_reg(CFG_SEED, 32'd0);
		add_random_points(100);
		wait_drained();
		write_reg(CFG_OCTAVES, 32'd1);
		write_reg(CFG_LACUN, 32'd2048);
		write_reg(CFG_BASERES, 32'd4096);
		add_random_points(100);
		wait_drained();

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(CFG_OCTAVES, $urandom_range(1, 8));
			write_reg(CFG_PERSIST, $urandom);
			write_reg(CFG_LACUN, ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(256, 2048));
			write_reg(CFG_BASERES, ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(1, 4096));
			write_reg(CFG_SEED, $urandom);
			add_random_points(125);
			wait_drained();
		end

		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
